// ===== rtl/lru_clean_page_replacement_core_assert.svh =====
// Assertion macros for the LRU clean-page replacement core.
// Included by the top level; expects signals named clock and reset in scope.
`ifndef LRU_CLEAN_PAGE_REPLACEMENT_CORE_ASSERT_SVH
`define LRU_CLEAN_PAGE_REPLACEMENT_CORE_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define LRUCP_ASSERT_HOLDS(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("lrucp: same-cycle check failed");

// Consequent must hold in the cycle after the antecedent.
`define LRUCP_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("lrucp: next-cycle check failed");

`endif

// ===== rtl/lrucp_pkg.sv =====
// Shared constants and types for the LRU clean-page replacement core.
// No dependencies; used by the channel interfaces, the entry RAM and the top level.
package lrucp_pkg;

   localparam int DEPTH = 16;
   localparam int POS_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam int ID_W  = 16;
   localparam int CAP_W = 5;
   localparam int CMP_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;

   localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

   typedef logic [1:0] outcome_type;
   localparam outcome_type OUT_HIT    = 2'd0;
   localparam outcome_type OUT_APPEND = 2'd1;
   localparam outcome_type OUT_EVICT  = 2'd2;
   localparam outcome_type OUT_FULL   = 2'd3;

   typedef struct packed {
      logic [ID_W-1:0] segment_id;
      logic [ID_W-1:0] page_id;
      logic            dirty;
   } entry_type;

   typedef struct packed {
      logic             en;
      logic [POS_W-1:0] addr;
      entry_type        data;
   } ram_wr_type;

   typedef struct packed {
      logic             en;
      logic [POS_W-1:0] addr;
   } ram_rd_type;

endpackage

// ===== rtl/lrucp_channels.sv =====
// Valid/ready channel interfaces for requests, responses and the capacity register.
// Depends on lrucp_pkg for field widths and the outcome type.
interface lrucp_req_if;
   logic                        valid;
   logic                        ready;
   logic [lrucp_pkg::ID_W-1:0]  segment_id;
   logic [lrucp_pkg::ID_W-1:0]  page_id;
   logic                        modified;

   modport source (output valid, segment_id, page_id, modified, input ready);
   modport sink   (input valid, segment_id, page_id, modified, output ready);
endinterface

interface lrucp_rsp_if;
   logic                        valid;
   logic                        ready;
   lrucp_pkg::outcome_type      outcome;
   logic [lrucp_pkg::ID_W-1:0]  victim_segment;
   logic [lrucp_pkg::ID_W-1:0]  victim_page;

   modport source (output valid, outcome, victim_segment, victim_page, input ready);
   modport sink   (input valid, outcome, victim_segment, victim_page, output ready);
endinterface

interface lrucp_csr_if;
   logic                        valid;
   logic                        ready;
   logic [lrucp_pkg::CAP_W-1:0] capacity;

   modport source (output valid, capacity, input ready);
   modport sink   (input valid, capacity, output ready);
endinterface

// ===== rtl/lrucp_entry_ram.sv =====
// Entry store: one write port, one read port, registered read data.
// Depends on lrucp_pkg for the entry and port types.
module lrucp_entry_ram (
   input  logic                  clock,
   input  lrucp_pkg::ram_wr_type wr,
   input  lrucp_pkg::ram_rd_type rd,
   output lrucp_pkg::entry_type  rd_data
);

   lrucp_pkg::entry_type mem [lrucp_pkg::DEPTH];
   lrucp_pkg::entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr] <= wr.data;
      end
      if (rd.en) begin
         rd_data_ff <= mem[rd.addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/lru_clean_page_replacement_core.sv =====
// Top level of the LRU clean-page replacement core.
// Depends on lrucp_pkg, the channel interfaces, lrucp_entry_ram and the assertion header.
//
// The core holds up to DEPTH pages in a single-port-write, single-port-read RAM,
// kept in recency order: position 0 is least recent, position count-1 most recent.
// Each request (segment, page, modified) gives exactly one response. A hit stores
// the new modified flag and moves the page to the most recent position (outcome 0).
// A miss below capacity appends the page (outcome 1). A miss at capacity removes
// the least recent clean page and returns it (outcome 2) without inserting the new
// page; the caller retries. With no clean page the table is emptied (outcome 3).
// Victim fields read zero except on outcome 2. Capacity 0 acts as 1, values above
// DEPTH act as DEPTH; write it only while the core is idle. Timing: one request at
// a time. A scan reads every held entry, one per cycle, through the RAM read port;
// a hit or eviction then closes the gap by moving the younger entries down one
// position, one per cycle, and a hit writes the page back on top. No clearing
// pass is needed after reset.
module lru_clean_page_replacement_core (
   input  logic       clock,
   input  logic       reset,
   lrucp_req_if.sink  req_if,
   lrucp_rsp_if.source rsp_if,
   lrucp_csr_if.sink  csr_if
);

`include "lru_clean_page_replacement_core_assert.svh"

   localparam logic [2:0] ST_IDLE   = 3'd0;  // waiting for a request
   localparam logic [2:0] ST_SCAN   = 3'd1;  // read all held entries
   localparam logic [2:0] ST_DECIDE = 3'd2;  // pick hit / append / evict / full
   localparam logic [2:0] ST_SHIFT  = 3'd3;  // close the gap, one entry a cycle
   localparam logic [2:0] ST_PUT    = 3'd4;  // hit page written at MRU position
   localparam logic [2:0] ST_DONE   = 3'd5;  // hand result to the output register

   logic [2:0]                    state_ff, state_in;
   logic [lrucp_pkg::CNT_W-1:0]   count_ff, count_in;
   logic [lrucp_pkg::CAP_W-1:0]   capacity_ff;
   lrucp_pkg::entry_type          req_ff, req_in;

   // shared read pipeline for the scan and the shift
   logic [lrucp_pkg::POS_W-1:0]   rd_pos_ff, rd_pos_in;
   logic                          rd_more_ff, rd_more_in;
   logic [lrucp_pkg::POS_W-1:0]   last_ff, last_in;
   logic                          pipe_vld_ff, pipe_vld_in;
   logic [lrucp_pkg::POS_W-1:0]   pipe_pos_ff, pipe_pos_in;

   // scan results
   logic                          hit_found_ff, hit_found_in;
   logic [lrucp_pkg::POS_W-1:0]   hit_pos_ff, hit_pos_in;
   logic                          clean_found_ff, clean_found_in;
   logic [lrucp_pkg::POS_W-1:0]   clean_pos_ff, clean_pos_in;
   lrucp_pkg::entry_type          victim_ff, victim_in;
   logic                          is_hit_ff, is_hit_in;

   // result held until the output register frees up
   lrucp_pkg::outcome_type        outcome_ff, outcome_in;
   logic [lrucp_pkg::ID_W-1:0]    vseg_ff, vseg_in;
   logic [lrucp_pkg::ID_W-1:0]    vpage_ff, vpage_in;

   // output register
   logic                          rsp_valid_ff, rsp_valid_in;
   lrucp_pkg::outcome_type        rsp_outcome_ff, rsp_outcome_in;
   logic [lrucp_pkg::ID_W-1:0]    rsp_vseg_ff, rsp_vseg_in;
   logic [lrucp_pkg::ID_W-1:0]    rsp_vpage_ff, rsp_vpage_in;

   lrucp_pkg::ram_wr_type         ram_wr;
   lrucp_pkg::ram_rd_type         ram_rd;
   lrucp_pkg::entry_type          ram_q;

   logic                          req_take;
   logic                          rsp_take;
   logic                          rsp_free;
   logic [lrucp_pkg::CMP_W-1:0]   cap_ext;
   logic [lrucp_pkg::CMP_W-1:0]   eff_cap;
   logic                          has_room;
   logic                          key_match;

   lrucp_entry_ram u_entry_ram (
      .clock   (clock),
      .wr      (ram_wr),
      .rd      (ram_rd),
      .rd_data (ram_q)
   );

   assign req_if.ready = (state_ff == ST_IDLE);
   assign req_take     = req_if.valid && req_if.ready;
   assign csr_if.ready = 1'b1;

   assign rsp_take = rsp_valid_ff && rsp_if.ready;
   assign rsp_free = !rsp_valid_ff || rsp_if.ready;

   assign rsp_if.valid          = rsp_valid_ff;
   assign rsp_if.outcome        = rsp_outcome_ff;
   assign rsp_if.victim_segment = rsp_vseg_ff;
   assign rsp_if.victim_page    = rsp_vpage_ff;

   // capacity 0 acts as 1, anything above DEPTH acts as DEPTH
   assign cap_ext = lrucp_pkg::CMP_W'(capacity_ff);
   always_comb begin
      if (cap_ext == '0) begin
         eff_cap = lrucp_pkg::CMP_W'(1);
      end else if (cap_ext > lrucp_pkg::CMP_W'(lrucp_pkg::DEPTH)) begin
         eff_cap = lrucp_pkg::CMP_W'(lrucp_pkg::DEPTH);
      end else begin
         eff_cap = cap_ext;
      end
   end
   assign has_room = lrucp_pkg::CMP_W'(count_ff) < eff_cap;

   assign key_match = (ram_q.segment_id == req_ff.segment_id)
                   && (ram_q.page_id == req_ff.page_id);

   always_comb begin
      state_in       = state_ff;
      count_in       = count_ff;
      req_in         = req_ff;
      rd_pos_in      = rd_pos_ff;
      rd_more_in     = rd_more_ff;
      last_in        = last_ff;
      pipe_vld_in    = 1'b0;
      pipe_pos_in    = pipe_pos_ff;
      hit_found_in   = hit_found_ff;
      hit_pos_in     = hit_pos_ff;
      clean_found_in = clean_found_ff;
      clean_pos_in   = clean_pos_ff;
      victim_in      = victim_ff;
      is_hit_in      = is_hit_ff;
      outcome_in     = outcome_ff;
      vseg_in        = vseg_ff;
      vpage_in       = vpage_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_take;
      rsp_outcome_in = rsp_outcome_ff;
      rsp_vseg_in    = rsp_vseg_ff;
      rsp_vpage_in   = rsp_vpage_ff;
      ram_wr         = '0;
      ram_rd         = '0;

      case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               req_in.segment_id = req_if.segment_id;
               req_in.page_id    = req_if.page_id;
               req_in.dirty      = req_if.modified;
               rd_pos_in         = '0;
               rd_more_in        = (count_ff != '0);
               last_in           = lrucp_pkg::POS_W'(count_ff - 1'b1);
               hit_found_in      = 1'b0;
               clean_found_in    = 1'b0;
               state_in          = ST_SCAN;
            end
         end

         ST_SCAN: begin
            // issue one read per cycle, compare the entry returned in the next cycle
            if (rd_more_ff) begin
               ram_rd.en   = 1'b1;
               ram_rd.addr = rd_pos_ff;
               pipe_vld_in = 1'b1;
               pipe_pos_in = rd_pos_ff;
               rd_more_in  = (rd_pos_ff != last_ff);
               rd_pos_in   = rd_pos_ff + 1'b1;
            end
            if (pipe_vld_ff) begin
               if (!hit_found_ff && key_match) begin
                  hit_found_in = 1'b1;
                  hit_pos_in   = pipe_pos_ff;
               end
               if (!clean_found_ff && !ram_q.dirty) begin
                  clean_found_in = 1'b1;
                  clean_pos_in   = pipe_pos_ff;
                  victim_in      = ram_q;
               end
            end
            if (!rd_more_ff && !pipe_vld_ff) begin
               state_in = ST_DECIDE;
            end
         end

         ST_DECIDE: begin
            vseg_in  = '0;
            vpage_in = '0;
            if (hit_found_ff) begin
               outcome_in = lrucp_pkg::OUT_HIT;
               is_hit_in  = 1'b1;
               rd_pos_in  = hit_pos_ff + 1'b1;
               rd_more_in = 1'b1;
               state_in   = (hit_pos_ff == last_ff) ? ST_PUT : ST_SHIFT;
            end else if (has_room) begin
               outcome_in     = lrucp_pkg::OUT_APPEND;
               ram_wr.en      = 1'b1;
               ram_wr.addr    = lrucp_pkg::POS_W'(count_ff);
               ram_wr.data    = req_ff;
               count_in       = count_ff + 1'b1;
               state_in       = ST_DONE;
            end else if (clean_found_ff) begin
               outcome_in = lrucp_pkg::OUT_EVICT;
               vseg_in    = victim_ff.segment_id;
               vpage_in   = victim_ff.page_id;
               is_hit_in  = 1'b0;
               count_in   = count_ff - 1'b1;
               rd_pos_in  = clean_pos_ff + 1'b1;
               rd_more_in = 1'b1;
               state_in   = (clean_pos_ff == last_ff) ? ST_DONE : ST_SHIFT;
            end else begin
               // every page dirty: table dropped
               outcome_in = lrucp_pkg::OUT_FULL;
               count_in   = '0;
               state_in   = ST_DONE;
            end
         end

         ST_SHIFT: begin
            // read position p, write it to p-1 next cycle
            if (rd_more_ff) begin
               ram_rd.en   = 1'b1;
               ram_rd.addr = rd_pos_ff;
               pipe_vld_in = 1'b1;
               pipe_pos_in = rd_pos_ff - 1'b1;
               rd_more_in  = (rd_pos_ff != last_ff);
               rd_pos_in   = rd_pos_ff + 1'b1;
            end
            if (pipe_vld_ff) begin
               ram_wr.en   = 1'b1;
               ram_wr.addr = pipe_pos_ff;
               ram_wr.data = ram_q;
            end
            if (!rd_more_ff && !pipe_vld_ff) begin
               state_in = is_hit_ff ? ST_PUT : ST_DONE;
            end
         end

         ST_PUT: begin
            ram_wr.en   = 1'b1;
            ram_wr.addr = last_ff;
            ram_wr.data = req_ff;
            state_in    = ST_DONE;
         end

         ST_DONE: begin
            if (rsp_free) begin
               rsp_valid_in   = 1'b1;
               rsp_outcome_in = outcome_ff;
               rsp_vseg_in    = vseg_ff;
               rsp_vpage_in   = vpage_ff;
               state_in       = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         capacity_ff  <= lrucp_pkg::CAP_RESET;
         pipe_vld_ff  <= 1'b0;
         rd_more_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         pipe_vld_ff  <= pipe_vld_in;
         rd_more_ff   <= rd_more_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_if.valid && csr_if.ready) begin
            capacity_ff <= csr_if.capacity;
         end
      end
   end

   // payload and datapath registers
   always_ff @(posedge clock) begin
      req_ff         <= req_in;
      rd_pos_ff      <= rd_pos_in;
      last_ff        <= last_in;
      pipe_pos_ff    <= pipe_pos_in;
      hit_found_ff   <= hit_found_in;
      hit_pos_ff     <= hit_pos_in;
      clean_found_ff <= clean_found_in;
      clean_pos_ff   <= clean_pos_in;
      victim_ff      <= victim_in;
      is_hit_ff      <= is_hit_in;
      outcome_ff     <= outcome_in;
      vseg_ff        <= vseg_in;
      vpage_ff       <= vpage_in;
      rsp_outcome_ff <= rsp_outcome_in;
      rsp_vseg_ff    <= rsp_vseg_in;
      rsp_vpage_ff   <= rsp_vpage_in;
   end

   // table never grows past the RAM
   `LRUCP_ASSERT_HOLDS(a_count_bound, 1'b1, count_ff <= lrucp_pkg::CNT_W'(lrucp_pkg::DEPTH))
   // victim fields only carry data on an eviction
   `LRUCP_ASSERT_HOLDS(a_victim_zero, rsp_valid_ff && (rsp_outcome_ff != lrucp_pkg::OUT_EVICT), (rsp_vseg_ff == '0) && (rsp_vpage_ff == '0))
   // an accepted request always starts a scan
   `LRUCP_ASSERT_NEXT(a_take_scans, req_take, state_ff == ST_SCAN)
   // read data in flight only while scanning or shifting
   `LRUCP_ASSERT_HOLDS(a_pipe_busy, pipe_vld_ff, (state_ff == ST_SCAN) || (state_ff == ST_SHIFT))

endmodule
